// File: src/anchor_grid_detection_decode_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the anchor grid detection decoder
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANCHOR_GRID_DETECTION_DECODE_CORE_ASSERT_SVH
`define ANCHOR_GRID_DETECTION_DECODE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define AGDD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agdd: same-cycle check failed");

`define AGDD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agdd: next-cycle check failed");

`else

`define AGDD_ASSERT_SAME(lbl, ante, cons)

`define AGDD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: src/agdd_pkg.sv
// ----------------------------------------------------------------------------
// agdd_pkg
// Types, widths and reset constants shared by the detection decoder.
// ----------------------------------------------------------------------------
package agdd_pkg;

    localparam int NUM_CLASSES_DEFAULT = 80;
    localparam int NUM_ANCHORS_DEFAULT = 3;
    localparam int ANCHOR_SLOTS        = 3;

    localparam int VALUE_W  = 16;
    localparam int ELEM_W   = 7;
    localparam int CELL_W   = 8;
    localparam int ANCHOR_W = 2;
    localparam int CENTER_W = 20;
    localparam int SIZE_W   = 16;
    localparam int CLASS_W  = 7;
    localparam int STRIDE_W = 7;
    localparam int DIM_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

    localparam logic [ELEM_W-1:0] ELEM_OBJ    = 7'd4;
    localparam logic [ELEM_W-1:0] ELEM_CLASS0 = 7'd5;

    localparam logic [VALUE_W-1:0]  THR_RESET    = 16'd8192;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd8;
    localparam logic [DIM_W-1:0] ANCHOR_W_RESET [ANCHOR_SLOTS] = '{10'd10, 10'd16, 10'd33};
    localparam logic [DIM_W-1:0] ANCHOR_H_RESET [ANCHOR_SLOTS] = '{10'd13, 10'd30, 10'd23};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONF_THRESHOLD = 3'd0,
        REG_GRID_STRIDE    = 3'd1,
        REG_ANCHOR0_WIDTH  = 3'd2,
        REG_ANCHOR0_HEIGHT = 3'd3,
        REG_ANCHOR1_WIDTH  = 3'd4,
        REG_ANCHOR1_HEIGHT = 3'd5,
        REG_ANCHOR2_WIDTH  = 3'd6,
        REG_ANCHOR2_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  head_value;
        logic [ELEM_W-1:0]   elem_index;
        logic [CELL_W-1:0]   cell_col;
        logic [CELL_W-1:0]   cell_row;
        logic [ANCHOR_W-1:0] anchor_index;
    } head_item_t;

    typedef struct packed {
        logic signed [CENTER_W-1:0] center_x;
        logic signed [CENTER_W-1:0] center_y;
        logic [SIZE_W-1:0]          box_width;
        logic [SIZE_W-1:0]          box_height;
        logic [VALUE_W-1:0]         det_score;
        logic [CLASS_W-1:0]         obj_class;
    } det_item_t;

endpackage

// File: src/agdd_if.sv
// ----------------------------------------------------------------------------
// agdd stream interfaces
// Valid/ready channels for head values in and detections out.
// ----------------------------------------------------------------------------
interface agdd_head_if import agdd_pkg::*; ();
    logic       valid;
    logic       ready;
    head_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface agdd_det_if import agdd_pkg::*; ();
    logic      valid;
    logic      ready;
    det_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/agdd_mul_unit.sv
// ----------------------------------------------------------------------------
// agdd_mul_unit
// Shared signed by unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module agdd_mul_unit import agdd_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [MUL_A_W-1:0] op_a,
    input  logic [MUL_B_W-1:0]        op_b,
    output logic signed [MUL_P_W-1:0] product
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(op_a) * MUL_P_W'($signed({1'b0, op_b}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign product = prod_reg;

endmodule

// File: src/anchor_grid_detection_decode_core.sv
// ----------------------------------------------------------------------------
// anchor_grid_detection_decode_core
// Decodes one scale of an anchor grid detection head into boxes.
// ----------------------------------------------------------------------------
// Head values arrive on head_stream, one per request, tagged with element
// index, grid cell and anchor. Detections leave on det_stream; both are
// valid/ready channels. Registers are to be written by the user through
// cfg_we, cfg_index and cfg_wdata only while the block is idle; the block
// itself does not enforce it. Box, objectness and class elements are taken
// at one request per cycle while the decode sequencer is idle. The last
// class element of a cell starts the decode sequencer, which steps the one
// shared multiplier through the score, two centres, two squares and two
// anchor products and then loads the output register in ST_OUT;
// head_stream is not ready meanwhile. A cell that fails the threshold
// returns to idle from ST_CENTER_X instead. A finished detection sits in the
// output register; if det_stream stalls, the next cell still streams in and
// only its final decode step waits. Reset restores the default threshold,
// stride and anchors, clears the class maximum and empties the output
// register.
// ----------------------------------------------------------------------------
`include "anchor_grid_detection_decode_core_assert.svh"

module anchor_grid_detection_decode_core import agdd_pkg::*;
#(
    parameter int NUM_CLASSES = NUM_CLASSES_DEFAULT,
    parameter int NUM_ANCHORS = NUM_ANCHORS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    agdd_head_if.sink             head_stream,
    agdd_det_if.source            det_stream
);

    localparam logic [ELEM_W-1:0]   ELEM_LAST  = ELEM_W'(NUM_CLASSES + 4);
    localparam logic [ANCHOR_W-1:0] ANCHOR_TOP = ANCHOR_W'(NUM_ANCHORS - 1);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SCORE    = 9'b000000010,
        ST_CENTER_X = 9'b000000100,
        ST_CENTER_Y = 9'b000001000,
        ST_WSQ      = 9'b000010000,
        ST_WMUL     = 9'b000100000,
        ST_HSQ      = 9'b001000000,
        ST_HMUL     = 9'b010000000,
        ST_OUT      = 9'b100000000
    } state_t;

    function automatic logic [CENTER_W-1:0] center_round(input logic signed [MUL_P_W-1:0] p);
        logic [MUL_P_W-1:0] s;
        s = $unsigned(p) + MUL_P_W'(1024);
        return s[30:11];
    endfunction

    function automatic logic [SIZE_W-1:0] size_round(input logic signed [MUL_P_W-1:0] p);
        logic [MUL_P_W-1:0] s;
        s = $unsigned(p) + (MUL_P_W'(1) << 25);
        if (|s[MUL_P_W-1:42])
        begin
            return '1;
        end
        return s[41:26];
    endfunction

    function automatic logic [VALUE_W-1:0] score_sat(input logic signed [MUL_P_W-1:0] p);
        if (|p[MUL_P_W-1:31])
        begin
            return '1;
        end
        return p[30:15];
    endfunction

    state_t state_reg, state_next;

    logic [VALUE_W-1:0]  thr_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [DIM_W-1:0]    anchor_w_reg [ANCHOR_SLOTS];
    logic [DIM_W-1:0]    anchor_h_reg [ANCHOR_SLOTS];

    logic [VALUE_W-1:0]  raw_box_reg [4];
    logic [VALUE_W-1:0]  obj_reg;
    logic [VALUE_W-1:0]  best_prob_reg;
    logic [CLASS_W-1:0]  best_class_reg;
    logic [CELL_W-1:0]   col_reg;
    logic [CELL_W-1:0]   row_reg;
    logic [ANCHOR_W-1:0] anchor_reg;

    logic [VALUE_W-1:0]  score_reg;
    logic [CENTER_W-1:0] cx_reg;
    logic [CENTER_W-1:0] cy_reg;
    logic [SIZE_W-1:0]   bw_reg;

    det_item_t out_reg;
    logic      out_valid_reg;

    head_item_t              item;
    logic                    accept;
    logic                    is_class;
    logic                    is_last;
    logic                    out_free;
    logic                    pass;
    logic                    mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0]        mul_b;
    logic signed [MUL_P_W-1:0] product;

    assign item     = head_stream.data;
    assign head_stream.ready = (state_reg == ST_IDLE);
    assign accept   = head_stream.valid && head_stream.ready;
    assign is_class = (item.elem_index >= ELEM_CLASS0) && (item.elem_index <= ELEM_LAST);
    assign is_last  = (item.elem_index == ELEM_LAST);
    assign out_free = !out_valid_reg || det_stream.ready;
    assign pass     = (obj_reg >= thr_reg)
                      && ($unsigned(product) >= MUL_P_W'({thr_reg, 15'd0}));
    assign mul_en   = (state_reg != ST_IDLE) && (state_reg != ST_OUT);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SCORE:
            begin
                mul_a = MUL_A_W'(obj_reg);
                mul_b = MUL_B_W'(best_prob_reg);
            end
            ST_CENTER_X:
            begin
                mul_a = MUL_A_W'({raw_box_reg[0], 1'b0}) - MUL_A_W'(16384)
                        + MUL_A_W'({col_reg, 15'd0});
                mul_b = MUL_B_W'(stride_reg);
            end
            ST_CENTER_Y:
            begin
                mul_a = MUL_A_W'({raw_box_reg[1], 1'b0}) - MUL_A_W'(16384)
                        + MUL_A_W'({row_reg, 15'd0});
                mul_b = MUL_B_W'(stride_reg);
            end
            ST_WSQ:
            begin
                mul_a = MUL_A_W'({raw_box_reg[2], 1'b0});
                mul_b = {raw_box_reg[2], 1'b0};
            end
            ST_WMUL:
            begin
                mul_a = product[MUL_A_W-1:0];
                mul_b = MUL_B_W'(anchor_w_reg[anchor_reg]);
            end
            ST_HSQ:
            begin
                mul_a = MUL_A_W'({raw_box_reg[3], 1'b0});
                mul_b = {raw_box_reg[3], 1'b0};
            end
            ST_HMUL:
            begin
                mul_a = product[MUL_A_W-1:0];
                mul_b = MUL_B_W'(anchor_h_reg[anchor_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    agdd_mul_unit u_mul
    (
        .clk     (clk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_last)
                begin
                    state_next = ST_SCORE;
                end
            end
            ST_SCORE:    state_next = ST_CENTER_X;
            ST_CENTER_X: state_next = pass ? ST_CENTER_Y : ST_IDLE;
            ST_CENTER_Y: state_next = ST_WSQ;
            ST_WSQ:      state_next = ST_WMUL;
            ST_WMUL:     state_next = ST_HSQ;
            ST_HSQ:      state_next = ST_HMUL;
            ST_HMUL:     state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            stride_reg     <= STRIDE_RESET;
            anchor_w_reg   <= ANCHOR_W_RESET;
            anchor_h_reg   <= ANCHOR_H_RESET;
            best_prob_reg  <= '0;
            best_class_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_CONF_THRESHOLD: thr_reg         <= cfg_wdata[VALUE_W-1:0];
                    REG_GRID_STRIDE:    stride_reg      <= cfg_wdata[STRIDE_W-1:0];
                    REG_ANCHOR0_WIDTH:  anchor_w_reg[0] <= cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR0_HEIGHT: anchor_h_reg[0] <= cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR1_WIDTH:  anchor_w_reg[1] <= cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR1_HEIGHT: anchor_h_reg[1] <= cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR2_WIDTH:  anchor_w_reg[2] <= cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR2_HEIGHT: anchor_h_reg[2] <= cfg_wdata[DIM_W-1:0];
                    default:            thr_reg         <= thr_reg;
                endcase
            end
            if (accept && is_class)
            begin
                if (item.elem_index == ELEM_CLASS0)
                begin
                    best_prob_reg  <= item.head_value;
                    best_class_reg <= '0;
                end
                else if (item.head_value > best_prob_reg)
                begin
                    best_prob_reg  <= item.head_value;
                    best_class_reg <= CLASS_W'(item.elem_index - ELEM_CLASS0);
                end
            end
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (det_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (item.elem_index < ELEM_OBJ)
            begin
                raw_box_reg[item.elem_index[1:0]] <= item.head_value;
            end
            if (item.elem_index == ELEM_OBJ)
            begin
                obj_reg <= item.head_value;
            end
            if (is_last)
            begin
                col_reg    <= item.cell_col;
                row_reg    <= item.cell_row;
                anchor_reg <= (item.anchor_index > ANCHOR_TOP) ? ANCHOR_TOP
                                                               : item.anchor_index;
            end
        end
        if (state_reg == ST_CENTER_X)
        begin
            score_reg <= score_sat(product);
        end
        if (state_reg == ST_CENTER_Y)
        begin
            cx_reg <= center_round(product);
        end
        if (state_reg == ST_WSQ)
        begin
            cy_reg <= center_round(product);
        end
        if (state_reg == ST_HSQ)
        begin
            bw_reg <= size_round(product);
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg.center_x   <= $signed(cx_reg);
            out_reg.center_y   <= $signed(cy_reg);
            out_reg.box_width  <= bw_reg;
            out_reg.box_height <= size_round(product);
            out_reg.det_score  <= score_reg;
            out_reg.obj_class  <= best_class_reg;
        end
    end

    assign det_stream.valid = out_valid_reg;
    assign det_stream.data  = out_reg;

    `AGDD_ASSERT_NEXT(a_last_starts_decode, accept && is_last, state_reg == ST_SCORE)
    `AGDD_ASSERT_SAME(a_result_from_seq, $rose(out_valid_reg), $past(state_reg == ST_OUT))
    `AGDD_ASSERT_NEXT(a_out_step_loads, (state_reg == ST_OUT) && out_free,
                      out_valid_reg && (state_reg == ST_IDLE))

endmodule

// File: test/anchor_grid_detection_decode_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Detection decoder checker
// Watches the head and detection channels and the register write port. It
// keeps its own copy of the registers and of the per-cell decode state. It
// predicts the detection, if any, that each accepted head request causes, and
// compares every accepted detection, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module anchor_grid_detection_decode_core_checker import agdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    agdd_head_if                  head_mon,
    agdd_det_if                   det_mon,
    output int                    fail_count,
    output int                    pending
);

    localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_CLASS0 + ELEM_W'(NUM_CLASSES_DEFAULT - 1);

    logic [VALUE_W-1:0]  thr_q15;
    logic [STRIDE_W-1:0] stride_px;
    logic [DIM_W-1:0]    anchor_w [ANCHOR_SLOTS];
    logic [DIM_W-1:0]    anchor_h [ANCHOR_SLOTS];

    logic [VALUE_W-1:0]  box_raw [4] = '{default: '0};
    logic [VALUE_W-1:0]  obj_q15 = '0;
    logic [VALUE_W-1:0]  best_q15;
    logic [CLASS_W-1:0]  best_idx;

    det_item_t expected_dets [$];
    int fails = 0;
    int waiting = 0;

    assign fail_count = fails;
    assign pending = waiting;

    function automatic logic [CENTER_W-1:0] centre_q4(input logic [VALUE_W-1:0] v,
                                                      input logic [CELL_W-1:0] grid_pos,
                                                      input logic [STRIDE_W-1:0] stride);
        longint offset;
        longint scaled;
        offset = 2 * longint'(v) - 16384 + longint'(grid_pos) * 32768;
        scaled = offset * longint'(stride);
        return CENTER_W'((scaled + 1024) >>> 11);
    endfunction

    function automatic logic [SIZE_W-1:0] size_q4(input logic [VALUE_W-1:0] v,
                                                 input logic [DIM_W-1:0] anchor);
        longint twice;
        longint rounded;
        twice = 2 * longint'(v);
        rounded = (twice * twice * longint'(anchor) + (longint'(1) << 25)) >>> 26;
        return (rounded > 65535) ? SIZE_W'(65535) : SIZE_W'(rounded);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    task automatic absorb_head_value(input head_item_t req);
        det_item_t det;
        longint product;
        int slot;
        if (req.elem_index < ELEM_OBJ)
            box_raw[req.elem_index[1:0]] = req.head_value;
        else if (req.elem_index == ELEM_OBJ)
            obj_q15 = req.head_value;
        else if (req.elem_index <= ELEM_LAST)
        begin
            if (req.elem_index == ELEM_CLASS0)
            begin
                best_q15 = req.head_value;
                best_idx = '0;
            end
            else if (req.head_value > best_q15)
            begin
                best_q15 = req.head_value;
                best_idx = CLASS_W'(req.elem_index - ELEM_CLASS0);
            end
            product = longint'(obj_q15) * longint'(best_q15);
            if (req.elem_index == ELEM_LAST && obj_q15 >= thr_q15
                && product >= (longint'(thr_q15) << 15))
            begin
                slot = (req.anchor_index >= NUM_ANCHORS_DEFAULT) ? NUM_ANCHORS_DEFAULT - 1
                                                                 : int'(req.anchor_index);
                det.center_x = centre_q4(box_raw[0], req.cell_col, stride_px);
                det.center_y = centre_q4(box_raw[1], req.cell_row, stride_px);
                det.box_width = size_q4(box_raw[2], anchor_w[slot]);
                det.box_height = size_q4(box_raw[3], anchor_h[slot]);
                det.det_score = ((product >> 15) > 65535) ? VALUE_W'(65535)
                                                          : VALUE_W'(product >> 15);
                det.obj_class = best_idx;
                expected_dets = {expected_dets, det};
                waiting++;
            end
        end
    endtask

    task automatic compare_detection(input det_item_t got);
        det_item_t want;
        if (expected_dets.size() == 0)
            report_mismatch("detection with none outstanding, class", got.obj_class, -1);
        else
        begin
            want = expected_dets.pop_front();
            waiting--;
            if (got.center_x !== want.center_x)
                report_mismatch("center_x", got.center_x, want.center_x);
            if (got.center_y !== want.center_y)
                report_mismatch("center_y", got.center_y, want.center_y);
            if (got.box_width !== want.box_width)
                report_mismatch("box_width", got.box_width, want.box_width);
            if (got.box_height !== want.box_height)
                report_mismatch("box_height", got.box_height, want.box_height);
            if (got.det_score !== want.det_score)
                report_mismatch("det_score", got.det_score, want.det_score);
            if (got.obj_class !== want.obj_class)
                report_mismatch("obj_class", got.obj_class, want.obj_class);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_q15 = THR_RESET;
            stride_px = STRIDE_RESET;
            for (int i = 0; i < ANCHOR_SLOTS; i++)
            begin
                anchor_w[i] = ANCHOR_W_RESET[i];
                anchor_h[i] = ANCHOR_H_RESET[i];
            end
            best_q15 = '0;
            best_idx = '0;
            expected_dets.delete();
            waiting = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_CONF_THRESHOLD: thr_q15 = cfg_wdata[VALUE_W-1:0];
                    REG_GRID_STRIDE:    stride_px = cfg_wdata[STRIDE_W-1:0];
                    REG_ANCHOR0_WIDTH:  anchor_w[0] = cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR0_HEIGHT: anchor_h[0] = cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR1_WIDTH:  anchor_w[1] = cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR1_HEIGHT: anchor_h[1] = cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR2_WIDTH:  anchor_w[2] = cfg_wdata[DIM_W-1:0];
                    REG_ANCHOR2_HEIGHT: anchor_h[2] = cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (det_mon.valid && det_mon.ready)
                compare_detection(det_mon.data);
            if (head_mon.valid && head_mon.ready)
                absorb_head_value(head_mon.data);
        end
    end

endmodule

// File: test/anchor_grid_detection_decode_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Detection decoder testbench
// Drives head value requests into the decoder: a short directed set for the
// extremes, threshold edges, ties and ignored elements, then phases of random
// cells under changing register settings. Both channels idle at random, and
// the detection side holds off at length now and then. The checker beside the
// decoder predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module anchor_grid_detection_decode_core_tb;
    import agdd_pkg::*;

    localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_CLASS0 + ELEM_W'(NUM_CLASSES_DEFAULT - 1);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    mismatches;
    int                    pending_dets;

    int items_sent = 0;
    int dets_taken = 0;
    bit sender_burst = 1'b0;
    bit sink_burst = 1'b0;

    logic [VALUE_W-1:0]  plan_thr;
    logic [STRIDE_W-1:0] plan_stride;
    logic [DIM_W-1:0]    plan_w [ANCHOR_SLOTS];
    logic [DIM_W-1:0]    plan_h [ANCHOR_SLOTS];

    agdd_head_if head_ch ();
    agdd_det_if  det_ch ();

    anchor_grid_detection_decode_core dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .head_stream (head_ch),
        .det_stream  (det_ch)
    );

    anchor_grid_detection_decode_core_checker checker_inst
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .head_mon   (head_ch),
        .det_mon    (det_ch),
        .fail_count (mismatches),
        .pending    (pending_dets)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #1_500_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VALUE_W'(32768);
            2:       return VALUE_W'($urandom_range(32769, 65535));
            default: return VALUE_W'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_head(input logic [VALUE_W-1:0] v, input logic [ELEM_W-1:0] e,
                             input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
                             input logic [ANCHOR_W-1:0] anc);
        head_item_t req;
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            head_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.head_value = v;
        req.elem_index = e;
        req.cell_col = col;
        req.cell_row = row;
        req.anchor_index = anc;
        head_ch.data <= req;
        head_ch.valid <= 1'b1;
        do @(posedge clk); while (!head_ch.ready);
        if (e <= ELEM_LAST)
            items_sent++;
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge clk);
    endtask

    task automatic settle_and_configure(input int phase);
        head_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_dets == 0);
        repeat (16) @(posedge clk);
        if (phase == 0)
        begin
            plan_thr = '0;
            plan_stride = STRIDE_W'(1);
            plan_w = '{default: '0};
            plan_h = '{default: '0};
        end
        else if (phase == 1)
        begin
            plan_thr = VALUE_W'(32768);
            plan_stride = STRIDE_W'(64);
            plan_w = '{default: DIM_W'(1023)};
            plan_h = '{default: DIM_W'(1023)};
        end
        else
        begin
            plan_thr = VALUE_W'($urandom_range(0, 20000));
            plan_stride = STRIDE_W'($urandom_range(1, 64));
            for (int i = 0; i < ANCHOR_SLOTS; i++)
            begin
                plan_w[i] = DIM_W'($urandom_range(0, 1023));
                plan_h[i] = DIM_W'($urandom_range(0, 1023));
            end
        end
        write_reg(REG_CONF_THRESHOLD, plan_thr);
        write_reg(REG_GRID_STRIDE, CFG_DATA_W'(plan_stride));
        write_reg(REG_ANCHOR0_WIDTH, CFG_DATA_W'(plan_w[0]));
        write_reg(REG_ANCHOR0_HEIGHT, CFG_DATA_W'(plan_h[0]));
        write_reg(REG_ANCHOR1_WIDTH, CFG_DATA_W'(plan_w[1]));
        write_reg(REG_ANCHOR1_HEIGHT, CFG_DATA_W'(plan_h[1]));
        write_reg(REG_ANCHOR2_WIDTH, CFG_DATA_W'(plan_w[2]));
        write_reg(REG_ANCHOR2_HEIGHT, CFG_DATA_W'(plan_h[2]));
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        for (int i = 0; i < ELEM_OBJ; i++)
            send_head('0, ELEM_W'(i), '0, '0, 2'd0);
        send_head(VALUE_W'(32768), ELEM_OBJ, '0, '0, 2'd0);
        send_head(VALUE_W'(32768), ELEM_CLASS0, '0, '0, 2'd0);
        send_head('0, ELEM_LAST, '0, '0, 2'd0);

        for (int i = 0; i <= ELEM_OBJ; i++)
            send_head(VALUE_W'(65535), ELEM_W'(i), 8'd255, 8'd255, 2'd3);
        send_head(VALUE_W'(100), ELEM_CLASS0, 8'd255, 8'd255, 2'd3);
        send_head(VALUE_W'(65535), ELEM_LAST, 8'd255, 8'd255, 2'd3);

        // Equal scores keep the first class; elements past the last class
        // leave the state alone.
        send_head(VALUE_W'(20000), ELEM_OBJ, 8'd17, 8'd200, 2'd1);
        send_head(VALUE_W'(20000), ELEM_CLASS0, 8'd17, 8'd200, 2'd1);
        send_head(VALUE_W'(20000), ELEM_W'(40), 8'd17, 8'd200, 2'd1);
        send_head(VALUE_W'(50), ELEM_LAST + 7'd16, 8'd17, 8'd200, 2'd1);
        send_head(VALUE_W'(65535), ELEM_W'(127), 8'd17, 8'd200, 2'd1);
        send_head(VALUE_W'(20000), ELEM_LAST, 8'd17, 8'd200, 2'd1);

        // Objectness and score exactly at the threshold, then just below it.
        send_head(VALUE_W'(8192), ELEM_OBJ, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(32768), ELEM_CLASS0, 8'd3, 8'd5, 2'd2);
        send_head('0, ELEM_LAST, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(8191), ELEM_OBJ, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(32768), ELEM_CLASS0, 8'd3, 8'd5, 2'd2);
        send_head('0, ELEM_LAST, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(32768), ELEM_OBJ, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(8191), ELEM_CLASS0, 8'd3, 8'd5, 2'd2);
        send_head(VALUE_W'(8191), ELEM_LAST, 8'd3, 8'd5, 2'd2);
    endtask

    task automatic send_cell(input bit truncated);
        logic [CELL_W-1:0]   col;
        logic [CELL_W-1:0]   row;
        logic [ANCHOR_W-1:0] anc;
        logic [VALUE_W-1:0]  v;
        logic [VALUE_W-1:0]  prev;
        int elems [$];
        int e;
        int keep;
        col = CELL_W'($urandom_range(0, 255));
        row = CELL_W'($urandom_range(0, 255));
        anc = ANCHOR_W'($urandom_range(0, 3));
        sender_burst = ($urandom_range(0, 2) == 0);
        for (e = 0; e <= ELEM_CLASS0; e++)
            elems = {elems, e};
        if ($urandom_range(0, 3) == 0)
        begin
            for (e = ELEM_CLASS0 + 1; e <= ELEM_LAST; e++)
                elems = {elems, e};
        end
        else
        begin
            e = ELEM_CLASS0 + $urandom_range(1, 12);
            while (e < ELEM_LAST)
            begin
                elems = {elems, e};
                e += $urandom_range(1, 20);
            end
            elems = {elems, int'(ELEM_LAST)};
        end
        keep = truncated ? $urandom_range(1, elems.size() - 1) : elems.size();
        prev = '0;
        for (int i = 0; i < keep; i++)
        begin
            e = elems[i];
            if (e == ELEM_OBJ)
                v = ($urandom_range(0, 3) != 0) ? VALUE_W'($urandom_range(16384, 32768))
                                                : draw_value();
            else if (e > ELEM_OBJ && $urandom_range(0, 4) == 0)
                v = prev;
            else
                v = draw_value();
            prev = v;
            if (e != ELEM_LAST && $urandom_range(0, 5) == 0)
                send_head(v, ELEM_W'(e), CELL_W'($urandom_range(0, 255)),
                          CELL_W'($urandom_range(0, 255)), ANCHOR_W'($urandom_range(0, 3)));
            else
                send_head(v, ELEM_W'(e), col, row, anc);
        end
    endtask

    task automatic send_noise();
        sender_burst = ($urandom_range(0, 1) == 0);
        repeat ($urandom_range(1, 6))
            send_head(VALUE_W'($urandom_range(0, 65535)), ELEM_W'($urandom_range(0, 127)),
                      CELL_W'($urandom_range(0, 255)), CELL_W'($urandom_range(0, 255)),
                      ANCHOR_W'($urandom_range(0, 3)));
    endtask

    initial
    begin : detection_sink
        int stall;
        det_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (dets_taken % 12 == 0)
                sink_burst = ($urandom_range(0, 2) == 0);
            stall = sink_burst ? 0 : $urandom_range(0, 18);
            if (dets_taken == 10 || dets_taken == 45)
                stall = 300;
            if (stall > 0)
            begin
                det_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            det_ch.ready <= 1'b1;
            do @(posedge clk); while (!det_ch.valid);
            dets_taken++;
        end
    end

    initial
    begin : stimulus
        int phase;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_CONF_THRESHOLD;
        cfg_wdata <= '0;
        head_ch.valid <= 1'b0;
        head_ch.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        phase = 0;
        while (items_sent < 1950)
        begin
            settle_and_configure(phase);
            repeat ($urandom_range(6, 14))
            begin
                case ($urandom_range(0, 9))
                    7:       send_cell(1'b1);
                    8, 9:    send_noise();
                    default: send_cell(1'b0);
                endcase
                if ($urandom_range(0, 19) == 0)
                begin
                    head_ch.valid <= 1'b0;
                    @(posedge clk);
                    wait (pending_dets == 0);
                    @(posedge clk);
                end
            end
            phase++;
        end

        head_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_dets == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
